@@ hw/rtl/integer_ceil_cube_root_unit_assert.svh @@
`ifndef INTEGER_CEIL_CUBE_ROOT_UNIT_ASSERT_SVH
`define INTEGER_CEIL_CUBE_ROOT_UNIT_ASSERT_SVH

// same-cycle implication, sampled on aclk, off during reset
`define ICRU_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("icru check failed");

// next-cycle implication, sampled on aclk, off during reset
`define ICRU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("icru check failed");

`endif

@@ hw/rtl/icru_pkg.sv @@
package icru_pkg;

    localparam int ROOT_BITS    = 11;
    localparam int M_TDATA_BITS = ((ROOT_BITS + 7) / 8) * 8;

endpackage

@@ hw/rtl/icru_cell.sv @@
module icru_cell
    import icru_pkg::*;
#(
    parameter int INPUT_BITS = 31,
    parameter int RB         = 11,
    parameter int SHIFT      = 0
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [INPUT_BITS-1:0] in_rem,
    input  logic [RB-1:0]         in_y,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [INPUT_BITS-1:0] out_rem,
    output logic [RB-1:0]         out_y
);

    localparam int TW = 2 * RB + 2;
    localparam int CW = (INPUT_BITS > TW) ? INPUT_BITS : TW;

    logic                  valid_reg;
    logic [INPUT_BITS-1:0] rem_reg, rem_next;
    logic [RB-1:0]         y_reg, y_next;
    logic [RB-1:0]         y_dbl;
    logic [TW-1:0]         y_w, prod, term;
    logic [CW-1:0]         rem_hi, term_sh;
    logic                  fits;

    // trial term 3y(y+1)+1 on the doubled partial root
    assign y_dbl   = in_y << 1;
    assign y_w     = TW'(y_dbl);
    assign prod    = y_w * (y_w + TW'(1));
    assign term    = prod + (prod << 1) + TW'(1);
    assign rem_hi  = CW'(in_rem) >> SHIFT;
    assign fits    = rem_hi >= CW'(term);
    assign term_sh = CW'(term) << SHIFT;

    always_comb begin
        if (fits) begin
            rem_next = in_rem - INPUT_BITS'(term_sh);
            y_next   = y_dbl | RB'(1);
        end else begin
            rem_next = in_rem;
            y_next   = y_dbl;
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_y     = y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            rem_reg <= rem_next;
            y_reg   <= y_next;
        end
    end

endmodule

@@ hw/rtl/icru_fix.sv @@
module icru_fix
    import icru_pkg::*;
#(
    parameter int INPUT_BITS = 31,
    parameter int RB         = 11
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [INPUT_BITS-1:0] in_rem,
    input  logic [RB-1:0]         in_y,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [ROOT_BITS-1:0]  out_root
);

    logic                 valid_reg;
    logic [ROOT_BITS-1:0] root_reg;
    logic [RB:0]          root_next;

    // nonzero remainder means the input is not an exact cube
    assign root_next = {1'b0, in_y} + (RB + 1)'(in_rem != '0);

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_root  = root_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            root_reg <= ROOT_BITS'(root_next);
        end
    end

endmodule

@@ hw/rtl/integer_ceil_cube_root_unit.sv @@
// an accepted word is registered in each root-bit cell in turn and then in the fix stage before m_tvalid
// one word per cycle while m_tready allows, one root-bit cell per round plus a final fix stage
// each stage has its own valid and takes a new word whenever it is empty or draining
// reset: synchronous active-low aresetn clears all stage valid bits, data regs keep
`include "integer_ceil_cube_root_unit_assert.svh"
module integer_ceil_cube_root_unit
    import icru_pkg::*;
#(
    parameter int INPUT_BITS = 31
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((INPUT_BITS + 7) / 8) * 8 - 1:0] s_tdata,  // value
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [M_TDATA_BITS-1:0]                m_tdata    // root
);

    localparam int ROUNDS = (INPUT_BITS - 1) / 3 + 1;
    localparam int RB     = ROUNDS;

    logic                  valid_c [0:ROUNDS];
    logic                  ready_c [0:ROUNDS];
    logic [INPUT_BITS-1:0] rem_c   [0:ROUNDS];
    logic [RB-1:0]         y_c     [0:ROUNDS];
    logic [ROOT_BITS-1:0]  root;

    assign valid_c[0] = s_tvalid;
    assign s_tready   = ready_c[0];
    assign rem_c[0]   = s_tdata[INPUT_BITS-1:0];
    assign y_c[0]     = '0;

    for (genvar i = 0; i < ROUNDS; i++) begin : g_cell
        icru_cell #(
            .INPUT_BITS (INPUT_BITS),
            .RB         (RB),
            .SHIFT      (3 * (ROUNDS - 1 - i))
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (valid_c[i]),
            .in_ready  (ready_c[i]),
            .in_rem    (rem_c[i]),
            .in_y      (y_c[i]),
            .out_valid (valid_c[i+1]),
            .out_ready (ready_c[i+1]),
            .out_rem   (rem_c[i+1]),
            .out_y     (y_c[i+1])
        );
    end

    icru_fix #(
        .INPUT_BITS (INPUT_BITS),
        .RB         (RB)
    ) u_fix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (valid_c[ROUNDS]),
        .in_ready  (ready_c[ROUNDS]),
        .in_rem    (rem_c[ROUNDS]),
        .in_y      (y_c[ROUNDS]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_root  (root)
    );

    assign m_tdata = M_TDATA_BITS'(root);

    `ICRU_ASSERT_NOW(a_ready_chain, m_tready, s_tready)
    `ICRU_ASSERT_NEXT(a_fix_load, valid_c[ROUNDS] && ready_c[ROUNDS], m_tvalid)
    `ICRU_ASSERT_NEXT(a_first_load, s_tvalid && s_tready, valid_c[1])

endmodule
